/* rtl/bptc_pkg.sv */
// Shared types and constants of the barometer compensation core.
package bptc_pkg;

   localparam int RAW_W      = 24;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int DT_W       = 25;
   localparam int ACC_W      = 40;
   localparam int DELTA_W    = 19;
   localparam int SQ_W       = 36;
   localparam int TEMP_W     = 19;
   localparam int PRESS_W    = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE   = 19'sd2000;
   localparam logic signed [19:0]       COLD_OFFSET = 20'sd3500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS       = 3'd0,
      CSR_OFF        = 3'd1,
      CSR_SENS_TEMP  = 3'd2,
      CSR_OFF_TEMP   = 3'd3,
      CSR_REF_TEMP   = 3'd4,
      CSR_TEMP_SLOPE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [SQ_W-1:0]          sq_warm;
      logic [SQ_W-1:0]          sq_cold;
      logic                     below_warm;
      logic                     below_cold;
      logic signed [TEMP_W-1:0] temp;
   } comp_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic signed [TEMP_W-1:0] temp;
   } corr_type;

endpackage

/* rtl/baro_pressure_temp_compensation_core.sv */
// Top level of the barometer second-order temperature compensation core.
//
// The req channel takes one item per sample: raw pressure D1 and raw
// temperature D2. The rsp channel returns one item per request with the
// compensated pressure in 0.01 mbar and temperature in 0.01 degC, in order.
// The csr port writes the six calibration coefficients C1 to C6 at indexes
// zero to five; writes to other indexes are dropped. Coefficients are changed
// only while no item is in flight; the block itself does not enforce this.
// The datapath is an eight-stage pipeline: four stages for dT, the
// coefficient products and the squares, one for the second-order correction,
// and three for the split D1 x SENS product and the final pressure. One
// item is accepted in every cycle while the output is taken.
// Reset clears all stage valid bits and sets every coefficient to zero.
// When the receiver stalls, the last stage holds its item and earlier stages
// keep filling empty slots, so req_tready drops only once every stage is full.
module baro_pressure_temp_compensation_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: raw_pressure[23:0], raw_temperature[47:24].
   input  logic [bptc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: pressure[31:0], temperature[50:32], zero fill.
   output logic [bptc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bptc_pkg::COEF_W-1:0]         csr_wdata
);

   bptc_pkg::coef_type coef_ff;
   bptc_pkg::coef_type coef_in;
   bptc_pkg::comp_type comp_data;
   bptc_pkg::corr_type corr_data;

   logic comp_valid, comp_ready;
   logic corr_valid, corr_ready;
   logic signed [bptc_pkg::PRESS_W-1:0] pressure;
   logic signed [bptc_pkg::TEMP_W-1:0]  temperature;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            bptc_pkg::CSR_SENS:       coef_in.c1 = csr_wdata;
            bptc_pkg::CSR_OFF:        coef_in.c2 = csr_wdata;
            bptc_pkg::CSR_SENS_TEMP:  coef_in.c3 = csr_wdata;
            bptc_pkg::CSR_OFF_TEMP:   coef_in.c4 = csr_wdata;
            bptc_pkg::CSR_REF_TEMP:   coef_in.c5 = csr_wdata;
            bptc_pkg::CSR_TEMP_SLOPE: coef_in.c6 = csr_wdata;
            default:                  coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   bptc_temp_stage u_temp (
      .clock           (clock),
      .reset           (reset),
      .coef            (coef_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_pressure    (req_tdata[23:0]),
      .raw_temperature (req_tdata[47:24]),
      .out_valid       (comp_valid),
      .out_ready       (comp_ready),
      .out_data        (comp_data)
   );

   bptc_corr_stage u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comp_valid),
      .in_ready  (comp_ready),
      .in_data   (comp_data),
      .out_valid (corr_valid),
      .out_ready (corr_ready),
      .out_data  (corr_data)
   );

   bptc_press_stage u_press (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (corr_valid),
      .in_ready    (corr_ready),
      .in_data     (corr_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .pressure    (pressure),
      .temperature (temperature)
   );

   assign rsp_tdata = {5'd0, temperature, pressure};

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled although the output is being drained");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

/* rtl/bptc_temp_stage.sv */
// Four-stage front end: dT, coefficient products, first-order terms and squares.
module bptc_temp_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  bptc_pkg::coef_type              coef,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [bptc_pkg::RAW_W-1:0]      raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]      raw_temperature,
   output logic                            out_valid,
   input  logic                            out_ready,
   output bptc_pkg::comp_type              out_data
);

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   logic [4:0] en;

   logic signed [bptc_pkg::DT_W-1:0]  dt_in, dt_ff;
   logic [bptc_pkg::RAW_W-1:0]        d1_s1_ff, d1_s2_ff, d1_s3_ff, d1_s4_ff;

   logic signed [41:0] p_off_in, p_off_ff;
   logic signed [41:0] p_sens_in, p_sens_ff;
   logic signed [41:0] p_temp_in, p_temp_ff;
   logic signed [49:0] p_dt2_in, p_dt2_ff;

   logic signed [41:0] p_off_sh, p_sens_sh, p_temp_sh;
   logic [49:0]        p_dt2_sh;

   logic signed [bptc_pkg::ACC_W-1:0]   off_s3_in, off_s3_ff, off_s4_ff;
   logic signed [bptc_pkg::ACC_W-1:0]   sens_s3_in, sens_s3_ff, sens_s4_ff;
   logic signed [bptc_pkg::DELTA_W-1:0] delta_in, delta_ff;
   logic [17:0]                         dtsq_in, dtsq_ff;

   logic signed [19:0]                  cold_delta;
   logic signed [37:0]                  sq_warm_full;
   logic signed [39:0]                  sq_cold_full;
   logic [bptc_pkg::SQ_W-1:0]           sq_warm_in, sq_warm_ff;
   logic [bptc_pkg::SQ_W-1:0]           sq_cold_in, sq_cold_ff;
   logic                                below_warm_in, below_warm_ff;
   logic                                below_cold_in, below_cold_ff;
   logic signed [bptc_pkg::TEMP_W-1:0]  temp_in, temp_ff;

   always_comb begin
      en[4] = out_ready;
      for (int i = 3; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];
   assign valid_in = {valid_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (en[3:0] & valid_in) | (~en[3:0] & valid_ff);
      end
   end

   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'd0});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= raw_pressure;
      end
   end

   assign p_off_in  = dt_ff * $signed({1'b0, coef.c4});
   assign p_sens_in = dt_ff * $signed({1'b0, coef.c3});
   assign p_temp_in = dt_ff * $signed({1'b0, coef.c6});
   assign p_dt2_in  = dt_ff * dt_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_off_ff  <= p_off_in;
         p_sens_ff <= p_sens_in;
         p_temp_ff <= p_temp_in;
         p_dt2_ff  <= p_dt2_in;
         d1_s2_ff  <= d1_s1_ff;
      end
   end

   assign p_off_sh  = p_off_ff >>> 7;
   assign p_sens_sh = p_sens_ff >>> 8;
   assign p_temp_sh = p_temp_ff >>> 23;
   assign p_dt2_sh  = p_dt2_ff >> 31;

   assign off_s3_in  = $signed({8'd0, coef.c2, 16'd0}) + $signed(p_off_sh[39:0]);
   assign sens_s3_in = $signed({9'd0, coef.c1, 15'd0}) + $signed(p_sens_sh[39:0]);
   assign delta_in   = p_temp_sh[18:0];
   assign dtsq_in    = p_dt2_sh[17:0];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         off_s3_ff  <= off_s3_in;
         sens_s3_ff <= sens_s3_in;
         delta_ff   <= delta_in;
         dtsq_ff    <= dtsq_in;
         d1_s3_ff   <= d1_s2_ff;
      end
   end

   assign cold_delta    = $signed({delta_ff[18], delta_ff}) + bptc_pkg::COLD_OFFSET;
   assign below_warm_in = delta_ff[18];
   assign below_cold_in = cold_delta[19];
   assign sq_warm_full  = delta_ff * delta_ff;
   assign sq_cold_full  = cold_delta * cold_delta;
   assign sq_warm_in    = sq_warm_full[bptc_pkg::SQ_W-1:0];
   assign sq_cold_in    = sq_cold_full[bptc_pkg::SQ_W-1:0];
   assign temp_in       = delta_ff + bptc_pkg::TEMP_BASE
                          - (below_warm_in ? $signed({1'b0, dtsq_ff}) : 19'sd0);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         off_s4_ff     <= off_s3_ff;
         sens_s4_ff    <= sens_s3_ff;
         sq_warm_ff    <= sq_warm_in;
         sq_cold_ff    <= sq_cold_in;
         below_warm_ff <= below_warm_in;
         below_cold_ff <= below_cold_in;
         temp_ff       <= temp_in;
         d1_s4_ff      <= d1_s3_ff;
      end
   end

   assign out_valid           = valid_ff[3];
   assign out_data.d1         = d1_s4_ff;
   assign out_data.off        = off_s4_ff;
   assign out_data.sens       = sens_s4_ff;
   assign out_data.sq_warm    = sq_warm_ff;
   assign out_data.sq_cold    = sq_cold_ff;
   assign out_data.below_warm = below_warm_ff;
   assign out_data.below_cold = below_cold_ff;
   assign out_data.temp       = temp_ff;

   a_cold_implies_warm: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && below_cold_ff |-> below_warm_ff)
      else $error("cold correction flagged without warm correction");

   a_warm_temp_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !below_warm_ff |-> temp_ff >= bptc_pkg::TEMP_BASE)
      else $error("uncorrected temperature below the base point");

endmodule

/* rtl/bptc_corr_stage.sv */
// Second-order correction of offset and sensitivity, one register stage.
module bptc_corr_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bptc_pkg::comp_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bptc_pkg::corr_type   out_data
);

   logic valid_ff;
   logic en;

   logic [bptc_pkg::ACC_W-1:0] five_sq;
   logic [bptc_pkg::ACC_W-1:0] seven_sq;
   logic [bptc_pkg::ACC_W-1:0] eleven_sq;
   logic [bptc_pkg::ACC_W-1:0] off_dec_warm, off_dec_cold;
   logic [bptc_pkg::ACC_W-1:0] sens_dec_warm, sens_dec_cold;

   bptc_pkg::corr_type data_in, data_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign five_sq   = {2'd0, in_data.sq_warm, 2'd0} + {4'd0, in_data.sq_warm};
   assign seven_sq  = {1'd0, in_data.sq_cold, 3'd0} - {4'd0, in_data.sq_cold};
   assign eleven_sq = {1'd0, in_data.sq_cold, 3'd0} + {3'd0, in_data.sq_cold, 1'd0}
                      + {4'd0, in_data.sq_cold};

   assign off_dec_warm  = in_data.below_warm ? {1'd0, five_sq[39:1]} : '0;
   assign sens_dec_warm = in_data.below_warm ? {2'd0, five_sq[39:2]} : '0;
   assign off_dec_cold  = in_data.below_cold ? seven_sq : '0;
   assign sens_dec_cold = in_data.below_cold ? {1'd0, eleven_sq[39:1]} : '0;

   always_comb begin
      data_in.d1   = in_data.d1;
      data_in.temp = in_data.temp;
      data_in.off  = in_data.off - $signed(off_dec_warm) - $signed(off_dec_cold);
      data_in.sens = in_data.sens - $signed(sens_dec_warm) - $signed(sens_dec_cold);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/bptc_press_stage.sv */
// Three-stage back end: split D1 x SENS product, recombination and final pressure.
module bptc_press_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  bptc_pkg::corr_type                    in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [bptc_pkg::PRESS_W-1:0]   pressure,
   output logic signed [bptc_pkg::TEMP_W-1:0]    temperature
);

   logic [2:0] valid_ff;
   logic [2:0] valid_in;
   logic [3:0] en;

   logic [43:0]        pp_lo_in, pp_lo_ff;
   logic signed [44:0] pp_hi_in, pp_hi_ff;
   logic signed [bptc_pkg::ACC_W-1:0]  off_s1_ff, off_s2_ff;
   logic signed [bptc_pkg::TEMP_W-1:0] temp_s1_ff, temp_s2_ff, temp_s3_ff;

   logic [63:0] prod_in, prod_ff;
   logic [43:0] diff;
   logic [bptc_pkg::PRESS_W-1:0] press_in, press_ff;

   always_comb begin
      en[3] = out_ready;
      for (int i = 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];
   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (en[2:0] & valid_in) | (~en[2:0] & valid_ff);
      end
   end

   assign pp_lo_in = in_data.d1 * in_data.sens[19:0];
   assign pp_hi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         off_s1_ff  <= in_data.off;
         temp_s1_ff <= in_data.temp;
      end
   end

   assign prod_in = {pp_hi_ff[43:0], 20'd0} + {20'd0, pp_lo_ff};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff    <= prod_in;
         off_s2_ff  <= off_s1_ff;
         temp_s2_ff <= temp_s1_ff;
      end
   end

   assign diff     = {prod_ff[63], prod_ff[63:21]} - {{4{off_s2_ff[39]}}, off_s2_ff};
   assign press_in = {{3{diff[43]}}, diff[43:15]};

   always_ff @(posedge clock) begin
      if (en[2]) begin
         press_ff   <= press_in;
         temp_s3_ff <= temp_s2_ff;
      end
   end

   assign out_valid   = valid_ff[2];
   assign pressure    = $signed(press_ff);
   assign temperature = temp_s3_ff;

endmodule
